[hw/rtl/pdsk_pkg.sv]
// ----------------------------------------------------------------------------
// pdsk_pkg
// shared types and constants of the particle density speed kernel
// ----------------------------------------------------------------------------
`default_nettype none

package pdsk_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_DEPOSIT = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_RHO_LOW    = 2'd0;
  localparam logic [1:0] CFG_RHO_HIGH   = 2'd1;
  localparam logic [1:0] CFG_MIN_SPEED  = 2'd2;
  localparam logic [1:0] CFG_BIN_OFFSET = 2'd3;

  // shared divider widths
  localparam int DIV_DW = 48;
  localparam int DIV_VW = 32;

  // slope scale: 0.2 in Q4.12 gives 1/20480
  localparam int SLOPE_DEN = 20480;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_Q_RD,
    ST_Q_DATA,
    ST_Q_WAIT,
    ST_Q_NEXT,
    ST_RHO_WAIT,
    ST_RAMP,
    ST_DROP_MUL,
    ST_DROP_GO,
    ST_DROP_WAIT,
    ST_SCALE,
    ST_SPD_GO,
    ST_SPD_WAIT,
    ST_DONE
  } pdsk_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } pdsk_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } pdsk_div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/pdsk_in_if.sv]
// ----------------------------------------------------------------------------
// pdsk_in_if
// input item channel: valid, ready and the item fields
// ----------------------------------------------------------------------------
`default_nettype none

interface pdsk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [13:0]        bin_index;
  logic [15:0]        bin_width;
  logic signed [15:0] bin_slope;
  logic signed [23:0] position;
  logic [15:0]        max_speed;
  logic [24:0]        start_time;
  logic [24:0]        now;

  modport source (
    output valid, operation, bin_index, bin_width, bin_slope, position,
           max_speed, start_time, now,
    input  ready
  );
  modport sink (
    input  valid, operation, bin_index, bin_width, bin_slope, position,
           max_speed, start_time, now,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/pdsk_out_if.sv]
// ----------------------------------------------------------------------------
// pdsk_out_if
// result channel: valid, ready and the result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface pdsk_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed;
  logic [15:0] density;
  logic        started;

  modport source (output valid, speed, density, started, input ready);
  modport sink (input valid, speed, density, started, output ready);
endinterface

`default_nettype wire

[hw/rtl/particle_density_speed_kernel.sv]
// ----------------------------------------------------------------------------
// particle_density_speed_kernel
// crowd-flow speed from a density histogram and a per-bin width/slope table
// ----------------------------------------------------------------------------
// channels: in_ch takes items (write table entry, clear histogram, deposit a
// position, query speed); out_ch gives one result per query only. a transfer
// happens on a clock edge with valid and ready both high. cfg_we/cfg_index/
// cfg_wdata write the four registers; the user must write them only while
// the block is idle, which it does not enforce. the histogram and the
// width/slope table sit in registered-read rams; the control reads, updates
// and writes back one bin at a time. per item: a deposit updates up to two
// bins, a clear sweeps every bin, and a query reads each window bin and, for
// a bin on the table with a nonzero width, makes one pass of the shared
// divider; the window average is a reciprocal multiply, then up to two more
// divider passes follow for the speed drop and the slope scaling.
// reset: the histogram is swept to zero with in_ch.ready low; configuration
// registers take their defaults; table entries stay undefined until written.
// when out_ch stalls, the finished result waits in the output register and
// the next item is still taken; a second query waits in its last step until
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_density_speed_kernel
  import pdsk_pkg::*;
#(
  parameter int NUM_BINS = 16384,
  parameter int WINDOW   = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pdsk_in_if.sink          in_ch,
  pdsk_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int BW   = $clog2(NUM_BINS);
  localparam int SW   = (BW + 2 > 19) ? BW + 2 : 19;      // signed bin index
  localparam int KW   = $clog2(WINDOW + 1);
  localparam int SUMW = 24 + $clog2(WINDOW + 1);
  // window average: sum * RECIP >> RS is exact for every sum below 2^SUMW
  localparam int RS   = SUMW + $clog2(WINDOW);
  localparam logic [SUMW:0] RECIP =
    (SUMW + 1)'(((64'd1 << RS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // configuration registers
  logic [15:0] rho_low_r, rho_high_r, min_speed_r;
  logic [13:0] bin_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_low_r    <= 16'd26;
      rho_high_r   <= 16'd128;
      min_speed_r  <= 16'd512;
      bin_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RHO_LOW:    rho_low_r    <= cfg_wdata;
        CFG_RHO_HIGH:   rho_high_r   <= cfg_wdata;
        CFG_MIN_SPEED:  min_speed_r  <= cfg_wdata;
        CFG_BIN_OFFSET: bin_offset_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  pdsk_state_t state_r, state_nxt;

  // item registers
  logic signed [SW-1:0] base_r;
  logic [7:0]           frac_r;
  logic                 second_r;
  logic [KW-1:0]        k_r;
  logic [15:0]          vmax_r;
  logic                 started_r;
  logic [BW-1:0]        clr_cnt_r;

  // query datapath registers
  logic [SUMW-1:0]      sum_r;
  logic signed [15:0]   slope_r;
  logic [15:0]          rho_r;
  logic [15:0]          dd_r, d_r;
  logic [32:0]          mul_r;
  logic signed [33:0]   num_r;
  logic [30:0]          den_r;
  logic [15:0]          v_r;
  logic [47:0]          prod_r;
  logic [15:0]          spd_r;

  logic        out_valid_r;
  logic [15:0] out_speed_r, out_density_r;
  logic        out_started_r;

  // memories
  logic          hist_we;
  logic [BW-1:0] hist_waddr;
  logic [15:0]   hist_wdata, hist_rdata;
  logic          tab_we;
  logic [31:0]   tab_rdata;
  logic [BW-1:0] rd_addr;

  pdsk_div_req_t div_req;
  pdsk_div_rsp_t div_rsp;

  logic accept, out_free, last_k, on_tab, tab_idx_ok;
  logic signed [SW-1:0] base_in, cur_b;
  logic [16:0]          dep_sum;
  logic [8:0]           dep_amt;
  logic [15:0]          dep_new;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign last_k   = k_r == KW'(WINDOW);

  // floor(position / 256) is an arithmetic shift
  assign base_in = SW'($signed(in_ch.position) >>> 8) + SW'(bin_offset_r);
  assign cur_b   = base_r + ((state_r == ST_DEP_RD || state_r == ST_DEP_WR)
                             ? SW'(second_r) : SW'(k_r));
  assign on_tab  = !cur_b[SW-1] && ($unsigned(cur_b) < SW'(NUM_BINS));
  assign rd_addr = cur_b[BW-1:0];
  assign tab_idx_ok = 32'(in_ch.bin_index) < NUM_BINS;

  // deposit: 256 - frac to the first bin, frac to the next, saturating
  assign dep_amt = second_r ? {1'b0, frac_r} : 9'd256 - {1'b0, frac_r};
  assign dep_sum = {1'b0, hist_rdata} + {8'd0, dep_amt};
  assign dep_new = dep_sum[16] ? 16'hFFFF : dep_sum[15:0];

  pdsk_ram #(.WIDTH(16), .DEPTH(NUM_BINS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  // table entry: slope in the upper half, width in the lower half
  pdsk_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (BW'(in_ch.bin_index)),
    .wdata ({in_ch.bin_slope, in_ch.bin_width}),
    .raddr (rd_addr),
    .rdata (tab_rdata)
  );

  pdsk_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == BW'(NUM_BINS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_CLEAR:   state_nxt = ST_CLEAR;
            OP_DEPOSIT: state_nxt = ST_DEP_RD;
            OP_QUERY:   state_nxt = ST_Q_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DEP_RD: begin
        if (on_tab) state_nxt = ST_DEP_WR;
        else if (second_r) state_nxt = ST_IDLE;
      end
      ST_DEP_WR:    state_nxt = second_r ? ST_IDLE : ST_DEP_RD;
      ST_Q_RD:      state_nxt = on_tab ? ST_Q_DATA : ST_Q_NEXT;
      ST_Q_DATA:    state_nxt = (tab_rdata[15:0] != '0) ? ST_Q_WAIT : ST_Q_NEXT;
      ST_Q_WAIT:    if (div_rsp.done) state_nxt = ST_Q_NEXT;
      ST_Q_NEXT:    state_nxt = last_k ? ST_RHO_WAIT : ST_Q_RD;
      ST_RHO_WAIT:  state_nxt = ST_RAMP;
      ST_RAMP:      state_nxt = ST_DROP_MUL;
      ST_DROP_MUL:  state_nxt = (min_speed_r <= vmax_r) ? ST_DROP_GO : ST_SCALE;
      ST_DROP_GO:   state_nxt = ST_DROP_WAIT;
      ST_DROP_WAIT: if (div_rsp.done) state_nxt = ST_SCALE;
      ST_SCALE:     state_nxt = (num_r > 34'sd0) ? ST_SPD_GO : ST_DONE;
      ST_SPD_GO:    state_nxt = ST_SPD_WAIT;
      ST_SPD_WAIT:  if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    hist_we     = 1'b0;
    hist_waddr  = rd_addr;
    hist_wdata  = dep_new;
    tab_we      = 1'b0;
    div_req     = '0;
    case (state_r)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_cnt_r;
        hist_wdata = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        tab_we      = accept && (in_ch.operation == OP_WRITE) && tab_idx_ok;
      end
      ST_DEP_WR: hist_we = 1'b1;
      ST_Q_DATA: begin
        div_req.start    = tab_rdata[15:0] != '0;
        div_req.dividend = DIV_DW'({hist_rdata, 8'd0});
        div_req.divisor  = DIV_VW'(tab_rdata[15:0]);
      end
      ST_DROP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(mul_r);
        div_req.divisor  = DIV_VW'(dd_r);
      end
      ST_SPD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = DIV_VW'(den_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      else clr_cnt_r <= '0;
    end
  end

  // ramp terms
  logic [15:0]        dd_nxt, d_nxt, rho_nxt, quo_sat;
  logic [16:0]        rho_diff;
  logic [2*SUMW:0]    rho_prod;
  logic [31:0]        drop_prod;
  logic signed [33:0] sl_ext, dmd_ext, slope_term;
  logic [30:0]        den_nxt;
  logic [47:0]        prod_nxt;

  assign rho_diff = {1'b0, rho_r} - {1'b0, rho_low_r};
  assign rho_prod = sum_r * RECIP;
  assign rho_nxt  = (|rho_prod[2*SUMW:RS+16]) ? 16'hFFFF : rho_prod[RS+15:RS];
  assign quo_sat  = (|div_rsp.quotient[DIV_DW-1:16]) ? 16'hFFFF
                                                     : div_rsp.quotient[15:0];

  always_comb begin
    if (rho_high_r > rho_low_r) begin
      dd_nxt = rho_high_r - rho_low_r;
      if (rho_r <= rho_low_r) d_nxt = '0;
      else if (rho_diff[15:0] >= dd_nxt) d_nxt = dd_nxt;
      else d_nxt = rho_diff[15:0];
    end else begin
      dd_nxt = 16'd1;
      d_nxt  = (rho_r > rho_low_r) ? 16'd1 : 16'd0;
    end
  end

  assign drop_prod  = 32'(vmax_r - min_speed_r) * 32'(d_r);
  assign sl_ext     = 34'(slope_r);
  assign dmd_ext    = $signed(34'(dd_r - d_r));
  assign slope_term = sl_ext * dmd_ext;
  assign den_nxt    = 31'(dd_r) * 31'(SLOPE_DEN);
  assign prod_nxt   = 48'(v_r) * 48'(num_r[31:0]) + 48'(den_r[30:1]);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        base_r    <= base_in;
        frac_r    <= in_ch.position[7:0];
        vmax_r    <= in_ch.max_speed;
        started_r <= in_ch.now >= in_ch.start_time;
        second_r  <= 1'b0;
        k_r       <= KW'(1);
        sum_r     <= '0;
        slope_r   <= '0;
      end
      ST_DEP_RD: if (!on_tab) second_r <= 1'b1;
      ST_DEP_WR: second_r <= 1'b1;
      ST_Q_DATA: if (k_r == KW'(1)) slope_r <= $signed(tab_rdata[31:16]);
      ST_Q_WAIT: if (div_rsp.done) sum_r <= sum_r + SUMW'(div_rsp.quotient[23:0]);
      ST_Q_NEXT: if (!last_k) k_r <= k_r + 1'b1;
      ST_RHO_WAIT: rho_r <= rho_nxt;
      ST_RAMP: begin
        dd_r <= dd_nxt;
        d_r  <= d_nxt;
      end
      ST_DROP_MUL: begin
        // speed drop dividend and slope scaling factor numerator and denominator
        mul_r <= 33'(drop_prod) + 33'(dd_r[15:1]);
        den_r <= den_nxt;
        num_r <= $signed(34'(den_nxt)) - slope_term;
        v_r   <= vmax_r;
      end
      ST_DROP_WAIT: if (div_rsp.done) v_r <= vmax_r - div_rsp.quotient[15:0];
      ST_SCALE: begin
        prod_r <= prod_nxt;
        spd_r  <= '0;
      end
      ST_SPD_WAIT: begin
        if (div_rsp.done) spd_r <= quo_sat;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_speed_r   <= started_r ? spd_r : 16'd0;
      out_density_r <= rho_r;
      out_started_r <= started_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.speed   = out_speed_r;
  assign out_ch.density = out_density_r;
  assign out_ch.started = out_started_r;

  // no item is taken during the histogram sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("item taken while histogram clears");

  // a result that has not started carries zero speed
  a_unstarted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.started |-> out_ch.speed == 16'd0)
    else $error("speed nonzero before start");

  // the divider is started only when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a result is never overwritten before its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.speed))
    else $error("pending result lost");

endmodule

`default_nettype wire

[hw/rtl/pdsk_ram.sv]
// ----------------------------------------------------------------------------
// pdsk_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pdsk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/pdsk_div.sv]
// ----------------------------------------------------------------------------
// pdsk_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdsk_div
  import pdsk_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pdsk_div_req_t req,
  output pdsk_div_rsp_t      rsp
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;

  logic [DIV_VW:0]   trial;
  logic              ge;
  logic [DIV_VW:0]   diff;

  assign trial = {rem_r, quo_r[DIV_DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      quo_r <= {quo_r[DIV_DW-2:0], ge};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire
